FILE: hw/rtl/hbow_pkg.sv
package hbow_pkg;

  // Field widths of one tick and one result.
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned TIMEOUT_W = 32;

  // Input request: cycle, owner token, peer beat, from the lowest bit up.
  localparam int unsigned IN_CYCLE_LSB = 0;
  localparam int unsigned IN_TOKEN_LSB = IN_CYCLE_LSB + WORD_W;
  localparam int unsigned IN_BEAT_LSB  = IN_TOKEN_LSB + WORD_W;
  localparam int unsigned IN_DATA_W    = IN_BEAT_LSB + WORD_W;

  // Result request: trip, own_heartbeat, trip_total, client_controls, padded to bytes.
  localparam int unsigned OUT_TRIP_LSB  = 0;
  localparam int unsigned OUT_OWN_LSB   = OUT_TRIP_LSB + 1;
  localparam int unsigned OUT_TOTAL_LSB = OUT_OWN_LSB + WORD_W;
  localparam int unsigned OUT_CTRL_LSB  = OUT_TOTAL_LSB + WORD_W;
  localparam int unsigned OUT_USED_W    = OUT_CTRL_LSB + 1;
  localparam int unsigned OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W     = OUT_DATA_W - OUT_USED_W;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_ENABLE  = 1'b0,
    CFG_TIMEOUT = 1'b1
  } cfg_idx_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic              client_controls;
    logic [WORD_W-1:0] trip_total;
    logic [WORD_W-1:0] own_heartbeat;
    logic              trip;
  } result_t;

endpackage

FILE: hw/rtl/heartbeat_ownership_watchdog_core.sv
// Channel   Ports                                  Width  Direction
// in_       in_tvalid / in_tready / in_tdata       192    tick requests in
// out_      out_tvalid / out_tready / out_tdata    136    result requests out
// cfg_      cfg_valid / cfg_ready / cfg_index,data 1+32   register writes in
//
// One tick is accepted every cycle unless the result stalls; its result passes through
// the input register and then the result register around the watchdog logic.
// Reset (rst_n low, synchronous) clears all counters, the watch state and the valid
// flags of both registers. A stalled result holds the result register and then the input
// register; in_tready drops only when both are full. cfg_ready is always high.
module heartbeat_ownership_watchdog_core
  import hbow_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Fields from bit 0: cycle[63:0], owner_token[127:64], peer_beat[191:128].
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: trip[0], own_heartbeat[64:1], trip_total[128:65],
  // client_controls[129], zero padding[135:130].
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [TIMEOUT_W-1:0]  cfg_data
);

  logic                 enable_r;
  logic [TIMEOUT_W-1:0] timeout_r;

  logic              s1_valid_r;
  logic [WORD_W-1:0] s1_cycle_r;
  logic [WORD_W-1:0] s1_token_r;
  logic [WORD_W-1:0] s1_beat_r;

  logic [WORD_W-1:0] watched_r, watched_nxt;
  logic [WORD_W-1:0] seen_r, seen_nxt;
  logic [WORD_W-1:0] progress_r, progress_nxt;
  logic [WORD_W-1:0] beats_r, beats_nxt;
  logic [WORD_W-1:0] trips_r, trips_nxt;

  logic              out_valid_r;
  result_t           res_r, res_nxt;

  logic              advance;
  logic [WORD_W-1:0] elapsed;
  logic              timed_out;

  // The result register empties or is taken; the input stage then moves on.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      timeout_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENABLE:  enable_r  <= cfg_data[0];
        CFG_TIMEOUT: timeout_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cycle_r <= in_tdata[IN_CYCLE_LSB +: WORD_W];
      s1_token_r <= in_tdata[IN_TOKEN_LSB +: WORD_W];
      s1_beat_r  <= in_tdata[IN_BEAT_LSB +: WORD_W];
    end
  end

  // Elapsed time is the modular 64-bit difference; the timeout is 32 bits wide.
  assign elapsed   = s1_cycle_r - progress_r;
  assign timed_out = (elapsed[WORD_W-1:TIMEOUT_W] == '0) ? (elapsed[TIMEOUT_W-1:0] >= timeout_r)
                                                         : 1'b1;

  // Watchdog decision for the tick in the input register.
  always_comb begin
    watched_nxt  = watched_r;
    seen_nxt     = seen_r;
    progress_nxt = progress_r;
    beats_nxt    = beats_r;
    trips_nxt    = trips_r;
    res_nxt.trip = 1'b0;
    if (enable_r) begin
      beats_nxt = beats_r + WORD_W'(1);
      if (s1_token_r != watched_r) begin
        // A new owner rebaselines the watch.
        watched_nxt  = s1_token_r;
        seen_nxt     = s1_beat_r;
        progress_nxt = s1_cycle_r;
      end else if (s1_token_r == '0) begin
        progress_nxt = s1_cycle_r;
      end else if (s1_beat_r != seen_r) begin
        seen_nxt     = s1_beat_r;
        progress_nxt = s1_cycle_r;
      end else if (timed_out) begin
        trips_nxt    = trips_r + WORD_W'(1);
        res_nxt.trip = 1'b1;
      end
    end
    res_nxt.own_heartbeat   = beats_nxt;
    res_nxt.trip_total      = trips_nxt;
    res_nxt.client_controls = enable_r && (s1_token_r != '0) && !res_nxt.trip;
  end

  // Watch state moves when the tick passes into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watched_r  <= '0;
      seen_r     <= '0;
      progress_r <= '0;
      beats_r    <= '0;
      trips_r    <= '0;
    end else if (advance && s1_valid_r) begin
      watched_r  <= watched_nxt;
      seen_r     <= seen_nxt;
      progress_r <= progress_nxt;
      beats_r    <= beats_nxt;
      trips_r    <= trips_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, res_r};

endmodule

FILE: hw/rtl/hbow_checker.sv
module hbow_checker
  import hbow_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  result_t           res;
  logic              have_prev_r;
  logic [WORD_W-1:0] prev_total_r;
  logic [WORD_W-1:0] prev_own_r;

  assign res = out_tdata[OUT_USED_W-1:0];

  // Remember the counters of the last result taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      have_prev_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      prev_total_r <= res.trip_total;
      prev_own_r   <= res.own_heartbeat;
    end
  end

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A trip revokes control in the same result.
  a_trip_revokes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.trip |-> !res.client_controls)
    else $error("client_controls set on a tripped tick");

  // The trip counter grows by exactly the trip flag from one result to the next.
  a_trip_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && have_prev_r |->
      res.trip_total == prev_total_r + WORD_W'(res.trip))
    else $error("trip_total does not follow the trip flags");

  // The own heartbeat holds or steps by one per tick.
  a_beat_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && have_prev_r |->
      (res.own_heartbeat == prev_own_r) || (res.own_heartbeat == prev_own_r + WORD_W'(1)))
    else $error("own_heartbeat skipped");

endmodule

bind heartbeat_ownership_watchdog_core hbow_checker u_hbow_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
